FILE: design/serial_lcd_terminal_core_macros.svh
// Assertion macros used by the checker file of the terminal core.
`ifndef SERIAL_LCD_TERMINAL_CORE_MACROS_SVH
`define SERIAL_LCD_TERMINAL_CORE_MACROS_SVH

// Checked property, disabled while reset is asserted.
`define SLT_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked property that also holds during reset.
`define SLT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/slt_pkg.sv
// Package with the types, codes and helpers of the serial LCD terminal.
package slt_pkg;

  localparam int COLUMNS_DEF = 16;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] LCD_LINE0 = 8'h80;
  localparam logic [7:0] LCD_LINE1 = 8'hC0;
  localparam logic [7:0] LCD_LINE_OFS = 8'h40;
  localparam logic [7:0] LCD_CMD_CLS = 8'h01;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_PRINT,
    OP_CR,
    OP_BS,
    OP_CLEAR,
    OP_CLRLINE,
    OP_DEL,
    OP_EOL,
    OP_BL_ON,
    OP_BL_OFF,
    OP_GOTO,
    OP_MOVE
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] arg;
  } queue_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_COPY_RD,
    ST_COPY_WR,
    ST_GOTO_PRE,
    ST_REF_HEAD0,
    ST_REF_RD,
    ST_REF_DATA,
    ST_REF_HEAD1,
    ST_REF_GOTO,
    ST_NOWRITE,
    ST_CLEAR_OUT,
    ST_GOTO_ONLY
  } back_state_t;

  function automatic logic is_letter(input logic [7:0] b, input logic [7:0] lower);
    return (b | 8'h20) == lower;
  endfunction

endpackage

FILE: design/serial_lcd_terminal_core.sv
// Top level of the serial LCD terminal: front end, operation queue and back end.
// Each received byte is classified at once and queued; the back end then carries it out and
// gives one result item per LCD write, or a single item without a write. A screen refresh
// writes the line 0 head, the characters of line 0, the line 1 head, the characters of line 1
// and a goto to the cursor; each character is first read from the text buffer, whose read is
// registered. A clear line, delete or clear to end of line sends a leading goto before it, and
// a scroll or a delete first copies the cells, each with a read and a write. A stall of the
// result channel holds the sequence. The backlight state shown is the one after the byte that
// caused the item. No clearing pass is needed after reset.
module serial_lcd_terminal_core import slt_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_has_write,
  output logic       out_register_select,
  output logic [7:0] out_lcd_byte,
  output logic       out_backlight_on,
  output logic       out_last
);

  queue_item_t front_item, back_item;
  logic        q_full, q_empty, q_pop, push;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  slt_front #(.COLUMNS(COLUMNS)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .rx_byte (in_rx_byte),
    .item    (front_item)
  );

  slt_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (front_item),
    .pop       (q_pop),
    .pop_item  (back_item),
    .full      (q_full),
    .empty     (q_empty)
  );

  slt_back #(.COLUMNS(COLUMNS)) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_empty             (q_empty),
    .q_item              (back_item),
    .q_pop               (q_pop),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_has_write       (out_has_write),
    .out_register_select (out_register_select),
    .out_lcd_byte        (out_lcd_byte),
    .out_backlight_on    (out_backlight_on),
    .out_last            (out_last)
  );

endmodule

FILE: design/slt_front.sv
// Front end: escape-command collection and classification of received bytes.
module slt_front import slt_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  logic [7:0]  rx_byte,
  output queue_item_t item
);

  localparam int CELLS = 2 * COLUMNS;
  localparam int CUR_W = $clog2(CELLS);

  logic       in_cmd_r, in_cmd_nxt;
  logic [2:0] count_r, count_nxt;
  logic [7:0] cmd0_r, cmd0_nxt;
  logic [7:0] cmd1_r, cmd1_nxt;
  logic [7:0] b0, b1, x8, y8;
  logic [CUR_W-1:0] pos;

  always_comb begin
    in_cmd_nxt = in_cmd_r;
    count_nxt  = count_r;
    cmd0_nxt   = cmd0_r;
    cmd1_nxt   = cmd1_r;
    item.op    = OP_NONE;
    item.arg   = rx_byte;
    b0 = (count_r == 3'd0) ? rx_byte : cmd0_r;
    b1 = (count_r == 3'd1) ? rx_byte : cmd1_r;
    x8 = b1 - CH_ZERO;
    y8 = rx_byte - CH_ZERO;
    if (x8 > 8'(COLUMNS - 1)) begin
      x8 = 8'(COLUMNS - 1);
    end
    pos = CUR_W'(x8) + ((y8 != 8'd0) ? CUR_W'(COLUMNS) : CUR_W'(0));
    if (rx_byte == CH_ESC) begin
      in_cmd_nxt = 1'b1;
      count_nxt  = 3'd0;
    end else if (in_cmd_r) begin
      count_nxt = count_r + 3'd1;
      cmd0_nxt  = b0;
      cmd1_nxt  = b1;
      if (count_nxt >= 3'd4) begin
        in_cmd_nxt = 1'b0;
      end else begin
        in_cmd_nxt = 1'b0;
        if (is_letter(b0, "c")) begin
          item.op = OP_CLEAR;
        end else if (is_letter(b0, "l")) begin
          item.op = OP_CLRLINE;
        end else if (is_letter(b0, "d")) begin
          item.op = OP_DEL;
        end else if (is_letter(b0, "e")) begin
          item.op = OP_EOL;
        end else if (is_letter(b0, "n")) begin
          item.op = OP_BL_ON;
        end else if (is_letter(b0, "f")) begin
          item.op = OP_BL_OFF;
        end else if (is_letter(b0, "g") && count_nxt == 3'd3) begin
          item.op  = OP_GOTO;
          item.arg = 8'(pos);
        end else if (is_letter(b0, "p") && count_nxt == 3'd2) begin
          item.op  = OP_MOVE;
          item.arg = b1;
        end else begin
          in_cmd_nxt = 1'b1;
        end
      end
    end else if (rx_byte == CH_CR) begin
      item.op = OP_CR;
    end else if (rx_byte == CH_BS) begin
      item.op = OP_BS;
    end else begin
      item.op = OP_PRINT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_cmd_r <= 1'b0;
      count_r  <= 3'd0;
      cmd0_r   <= 8'd0;
      cmd1_r   <= 8'd0;
    end else if (push) begin
      in_cmd_r <= in_cmd_nxt;
      count_r  <= count_nxt;
      cmd0_r   <= cmd0_nxt;
      cmd1_r   <= cmd1_nxt;
    end
  end

endmodule

FILE: design/slt_queue.sv
// Short queue of classified operations between the front and back ends.
module slt_queue import slt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  queue_item_t push_item,
  input  logic        pop,
  output queue_item_t pop_item,
  output logic        full,
  output logic        empty
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  queue_item_t      slots_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [PTR_W:0]   count_r;

  assign full     = (count_r == (PTR_W + 1)'(QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign pop_item = slots_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      count_r <= count_r + (PTR_W + 1)'(push) - (PTR_W + 1)'(pop);
    end
  end

endmodule

FILE: design/slt_back.sv
// Back end: text buffer, cursor, backlight and the LCD write sequencer.
module slt_back import slt_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_empty,
  input  queue_item_t q_item,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_has_write,
  output logic        out_register_select,
  output logic [7:0]  out_lcd_byte,
  output logic        out_backlight_on,
  output logic        out_last
);

  localparam int CELLS = 2 * COLUMNS;
  localparam int CUR_W = $clog2(CELLS);
  localparam int CNT_W = $clog2(CELLS + 1);

  back_state_t state_r, state_nxt, disp_st;

  logic [7:0]       text_mem [CELLS];
  logic [CELLS-1:0] vld_r, vld_nxt;
  logic [7:0]       rd_data_r;
  logic             rd_vld_r;
  logic [CUR_W-1:0] cursor_r, cursor_nxt;
  logic [CUR_W-1:0] idx_r, idx_nxt;
  logic [CUR_W-1:0] copy_dst_r, copy_dst_nxt;
  logic             scroll_r, scroll_nxt;
  logic             goto_pre_r, goto_pre_nxt;
  logic             backlight_r, backlight_nxt;
  logic             copy_done;

  logic             wr_en, rd_en, clr_en;
  logic [CUR_W-1:0] wr_addr, rd_addr;
  logic [7:0]       wr_data, cell_data;
  logic [CNT_W-1:0] clr_lo, clr_hi;

  logic             out_valid_r;
  logic             out_rs_r, out_hw_r, out_last_r, out_bl_r;
  logic [7:0]       out_byte_r;
  logic             can_load, ld, ld_rs, ld_hw, ld_last;
  logic [7:0]       ld_byte, goto_byte;
  logic [CUR_W-1:0] col;
  logic             on_line1;

  assign can_load  = !out_valid_r || !out_stall;
  assign on_line1  = (cursor_r >= CUR_W'(COLUMNS));
  assign col       = on_line1 ? cursor_r - CUR_W'(COLUMNS) : cursor_r;
  assign goto_byte = LCD_LINE0 + 8'(col) + (on_line1 ? LCD_LINE_OFS : 8'd0);
  assign cell_data = rd_vld_r ? rd_data_r : CH_SPACE;
  assign copy_done = scroll_r ? (copy_dst_r == CUR_W'(COLUMNS - 1))
                              : (copy_dst_r == CUR_W'(CELLS - 2));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:      if (!q_empty) state_nxt = disp_st;
      ST_COPY_RD:   state_nxt = ST_COPY_WR;
      ST_COPY_WR: begin
        if (copy_done) state_nxt = goto_pre_r ? ST_GOTO_PRE : ST_REF_HEAD0;
        else state_nxt = ST_COPY_RD;
      end
      ST_GOTO_PRE:  if (can_load) state_nxt = ST_REF_HEAD0;
      ST_REF_HEAD0: if (can_load) state_nxt = ST_REF_RD;
      ST_REF_RD:    state_nxt = ST_REF_DATA;
      ST_REF_DATA: begin
        if (can_load) begin
          if (idx_r == CUR_W'(COLUMNS - 1)) state_nxt = ST_REF_HEAD1;
          else if (idx_r == CUR_W'(CELLS - 1)) state_nxt = ST_REF_GOTO;
          else state_nxt = ST_REF_RD;
        end
      end
      ST_REF_HEAD1: if (can_load) state_nxt = ST_REF_RD;
      ST_REF_GOTO, ST_NOWRITE, ST_CLEAR_OUT, ST_GOTO_ONLY: begin
        if (can_load) state_nxt = ST_IDLE;
      end
      default:      state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    disp_st       = ST_NOWRITE;
    q_pop         = 1'b0;
    cursor_nxt    = cursor_r;
    idx_nxt       = idx_r;
    copy_dst_nxt  = copy_dst_r;
    scroll_nxt    = scroll_r;
    goto_pre_nxt  = goto_pre_r;
    backlight_nxt = backlight_r;
    wr_en   = 1'b0;
    wr_addr = cursor_r;
    wr_data = q_item.arg;
    rd_en   = 1'b0;
    rd_addr = idx_r;
    clr_en  = 1'b0;
    clr_lo  = CNT_W'(cursor_r);
    clr_hi  = on_line1 ? CNT_W'(CELLS) : CNT_W'(COLUMNS);
    ld      = 1'b0;
    ld_hw   = 1'b1;
    ld_rs   = 1'b0;
    ld_byte = goto_byte;
    ld_last = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop        = 1'b1;
          goto_pre_nxt = 1'b0;
          case (q_item.op)
            OP_PRINT: begin
              wr_en = 1'b1;
              if (cursor_r == CUR_W'(CELLS - 1)) begin
                scroll_nxt   = 1'b1;
                copy_dst_nxt = '0;
                disp_st      = ST_COPY_RD;
              end else begin
                cursor_nxt = cursor_r + 1'b1;
                disp_st    = ST_REF_HEAD0;
              end
            end
            OP_CR: begin
              if (on_line1) begin
                scroll_nxt   = 1'b1;
                copy_dst_nxt = '0;
                disp_st      = ST_COPY_RD;
              end else begin
                clr_en     = 1'b1;
                cursor_nxt = CUR_W'(COLUMNS);
                disp_st    = ST_REF_HEAD0;
              end
            end
            OP_BS: begin
              if (cursor_r != '0) begin
                cursor_nxt = cursor_r - 1'b1;
                clr_en     = 1'b1;
                clr_lo     = CNT_W'(cursor_r - 1'b1);
                clr_hi     = CNT_W'(cursor_r);
                disp_st    = ST_REF_HEAD0;
              end
            end
            OP_CLEAR: begin
              clr_en     = 1'b1;
              clr_lo     = '0;
              clr_hi     = CNT_W'(CELLS);
              cursor_nxt = '0;
              disp_st    = ST_CLEAR_OUT;
            end
            OP_CLRLINE: begin
              clr_en       = 1'b1;
              clr_lo       = on_line1 ? CNT_W'(COLUMNS) : '0;
              cursor_nxt   = on_line1 ? CUR_W'(COLUMNS) : '0;
              goto_pre_nxt = 1'b1;
              disp_st      = ST_GOTO_PRE;
            end
            OP_DEL: begin
              goto_pre_nxt = 1'b1;
              if (cursor_r == CUR_W'(CELLS - 1)) begin
                clr_en  = 1'b1;
                clr_hi  = CNT_W'(CELLS);
                disp_st = ST_GOTO_PRE;
              end else begin
                scroll_nxt   = 1'b0;
                copy_dst_nxt = cursor_r;
                disp_st      = ST_COPY_RD;
              end
            end
            OP_EOL: begin
              clr_en       = 1'b1;
              goto_pre_nxt = 1'b1;
              disp_st      = ST_GOTO_PRE;
            end
            OP_BL_ON:  backlight_nxt = 1'b1;
            OP_BL_OFF: backlight_nxt = 1'b0;
            OP_GOTO: begin
              cursor_nxt = q_item.arg[CUR_W-1:0];
              disp_st    = ST_GOTO_ONLY;
            end
            OP_MOVE: begin
              if (is_letter(q_item.arg, "l")) begin
                if (cursor_r != '0) cursor_nxt = cursor_r - 1'b1;
              end else if (is_letter(q_item.arg, "r")) begin
                if (cursor_r != CUR_W'(CELLS - 1)) cursor_nxt = cursor_r + 1'b1;
              end else if (is_letter(q_item.arg, "u")) begin
                if (on_line1) cursor_nxt = cursor_r - CUR_W'(COLUMNS);
              end else if (is_letter(q_item.arg, "d")) begin
                if (!on_line1) cursor_nxt = cursor_r + CUR_W'(COLUMNS);
              end
              disp_st = ST_GOTO_ONLY;
            end
            default: disp_st = ST_NOWRITE;
          endcase
        end
      end
      ST_COPY_RD: begin
        rd_en   = 1'b1;
        rd_addr = scroll_r ? copy_dst_r + CUR_W'(COLUMNS) : copy_dst_r + 1'b1;
      end
      ST_COPY_WR: begin
        wr_en        = 1'b1;
        wr_addr      = copy_dst_r;
        wr_data      = cell_data;
        copy_dst_nxt = copy_dst_r + 1'b1;
        if (copy_done) begin
          clr_en = 1'b1;
          clr_hi = CNT_W'(CELLS);
          if (scroll_r) begin
            clr_lo     = CNT_W'(COLUMNS);
            cursor_nxt = CUR_W'(COLUMNS);
          end else begin
            clr_lo = CNT_W'(CELLS - 1);
          end
        end
      end
      ST_GOTO_PRE: ld = 1'b1;
      ST_REF_HEAD0: begin
        ld      = 1'b1;
        ld_byte = LCD_LINE0;
        idx_nxt = '0;
      end
      ST_REF_RD: rd_en = 1'b1;
      ST_REF_DATA: begin
        ld      = 1'b1;
        ld_rs   = 1'b1;
        ld_byte = cell_data;
        if (can_load && idx_r != CUR_W'(COLUMNS - 1) && idx_r != CUR_W'(CELLS - 1)) begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_REF_HEAD1: begin
        ld      = 1'b1;
        ld_byte = LCD_LINE1;
        if (can_load) idx_nxt = idx_r + 1'b1;
      end
      ST_REF_GOTO, ST_GOTO_ONLY: begin
        ld      = 1'b1;
        ld_last = 1'b1;
      end
      ST_CLEAR_OUT: begin
        ld      = 1'b1;
        ld_byte = LCD_CMD_CLS;
        ld_last = 1'b1;
      end
      ST_NOWRITE: begin
        ld      = 1'b1;
        ld_hw   = 1'b0;
        ld_byte = 8'd0;
        ld_last = 1'b1;
      end
      default: ld = 1'b0;
    endcase
  end

  always_comb begin
    for (int i = 0; i < CELLS; i++) begin
      vld_nxt[i] = vld_r[i];
      if (clr_en && CNT_W'(i) >= clr_lo && CNT_W'(i) < clr_hi) vld_nxt[i] = 1'b0;
    end
    if (wr_en) vld_nxt[wr_addr] = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      text_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= text_mem[rd_addr];
      rd_vld_r  <= vld_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      vld_r       <= '0;
      cursor_r    <= '0;
      idx_r       <= '0;
      copy_dst_r  <= '0;
      scroll_r    <= 1'b0;
      goto_pre_r  <= 1'b0;
      backlight_r <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      vld_r       <= vld_nxt;
      cursor_r    <= cursor_nxt;
      idx_r       <= idx_nxt;
      copy_dst_r  <= copy_dst_nxt;
      scroll_r    <= scroll_nxt;
      goto_pre_r  <= goto_pre_nxt;
      backlight_r <= backlight_nxt;
      if (can_load) out_valid_r <= ld;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && ld) begin
      out_hw_r   <= ld_hw;
      out_rs_r   <= ld_rs;
      out_byte_r <= ld_byte;
      out_last_r <= ld_last;
      out_bl_r   <= backlight_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_has_write       = out_hw_r;
  assign out_register_select = out_rs_r;
  assign out_lcd_byte        = out_byte_r;
  assign out_backlight_on    = out_bl_r;
  assign out_last            = out_last_r;

endmodule

FILE: design/slt_checker.sv
// Port-level checker of the terminal core and its bind to the top level.
`include "serial_lcd_terminal_core_macros.svh"

module slt_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic [7:0] in_rx_byte,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_has_write,
  input logic       out_register_select,
  input logic [7:0] out_lcd_byte,
  input logic       out_backlight_on,
  input logic       out_last
);

  `SLT_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> !out_valid, "Result valid after reset.")
  `SLT_ASSERT(a_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_lcd_byte), "Stalled item changed.")
  `SLT_ASSERT(a_nowrite, clk, rst_n, out_valid && !out_has_write |-> out_last && !out_register_select && out_lcd_byte == 8'd0, "Malformed item without a write.")
  `SLT_ASSERT(a_data_not_last, clk, rst_n, out_valid && out_register_select |-> !out_last, "Character item marked as final.")

endmodule

bind serial_lcd_terminal_core slt_checker u_slt_checker (.*);

FILE: verif/tb_top.sv
// Self-checking testbench for the serial LCD terminal core.
`timescale 1ns / 100ps

module tb_top;
  import slt_pkg::*;

  localparam int COLS = COLUMNS_DEF;
  localparam int CELLS = 2 * COLS;
  localparam int LIMIT = 2000000;

  typedef struct {
    logic       has_write;
    logic       register_select;
    logic [7:0] lcd_byte;
    logic       backlight_on;
    logic       last;
  } lcd_write_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_rx_byte;
  logic       out_valid;
  logic       out_stall;
  logic       out_has_write;
  logic       out_register_select;
  logic [7:0] out_lcd_byte;
  logic       out_backlight_on;
  logic       out_last;

  logic [7:0] screen[CELLS];
  logic [4:0] crsr;
  logic       esc_mode;
  logic [2:0] esc_count;
  logic [7:0] esc_bytes[3];
  logic       lit;

  logic [7:0] pending_bytes[$];
  lcd_write_t expected_writes[$];
  lcd_write_t step_writes[$];

  int mismatches;
  int results_seen;
  int bytes_sent;
  int cycles;
  bit calm;
  bit hold_sender;
  int hold_off;

  serial_lcd_terminal_core u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_rx_byte(in_rx_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_has_write(out_has_write), .out_register_select(out_register_select),
    .out_lcd_byte(out_lcd_byte), .out_backlight_on(out_backlight_on),
    .out_last(out_last)
  );

  function automatic bit letter(input logic [7:0] b, input logic [7:0] lower);
    return (b | 8'h20) == lower;
  endfunction

  task automatic push_write(input logic rs, input logic [7:0] b);
    lcd_write_t w;
    w.has_write = 1'b1;
    w.register_select = rs;
    w.lcd_byte = b;
    w.backlight_on = 1'b0;
    w.last = 1'b0;
    step_writes.push_back(w);
  endtask

  task automatic push_goto();
    logic [7:0] v;
    v = LCD_LINE0 + 8'(crsr % COLS);
    if (crsr >= COLS) v = v + LCD_LINE_OFS;
    push_write(1'b0, v);
  endtask

  task automatic push_refresh();
    push_write(1'b0, LCD_LINE0);
    for (int i = 0; i < COLS; i++) push_write(1'b1, screen[i]);
    push_write(1'b0, LCD_LINE1);
    for (int i = COLS; i < CELLS; i++) push_write(1'b1, screen[i]);
    push_goto();
  endtask

  task automatic scroll_screen();
    for (int i = 0; i < COLS; i++) begin
      screen[i] = screen[i + COLS];
      screen[i + COLS] = CH_SPACE;
    end
    crsr = 5'(COLS);
  endtask

  task automatic run_escape();
    logic [7:0] k;
    logic [7:0] x;
    logic [7:0] y;
    int stop;
    k = esc_bytes[0];
    if (!esc_mode || esc_count == 0) return;
    if (letter(k, "c")) begin
      push_write(1'b0, LCD_CMD_CLS);
      for (int i = 0; i < CELLS; i++) screen[i] = CH_SPACE;
      crsr = 0;
      esc_mode = 0;
    end else if (letter(k, "l")) begin
      crsr = (crsr < COLS) ? 5'd0 : 5'(COLS);
      for (int i = 0; i < COLS; i++) screen[crsr + i] = CH_SPACE;
      esc_mode = 0;
      push_goto();
      push_refresh();
    end else if (letter(k, "d")) begin
      for (int i = crsr; i < CELLS - 1; i++) screen[i] = screen[i + 1];
      screen[CELLS - 1] = CH_SPACE;
      esc_mode = 0;
      push_goto();
      push_refresh();
    end else if (letter(k, "e")) begin
      stop = (crsr < COLS) ? COLS : CELLS;
      for (int i = crsr; i < stop; i++) screen[i] = CH_SPACE;
      esc_mode = 0;
      push_goto();
      push_refresh();
    end else if (letter(k, "n")) begin
      lit = 1;
      esc_mode = 0;
    end else if (letter(k, "f")) begin
      lit = 0;
      esc_mode = 0;
    end else if (letter(k, "g") && esc_count == 3) begin
      x = esc_bytes[1] - CH_ZERO;
      y = esc_bytes[2] - CH_ZERO;
      if (x > COLS - 1) x = COLS - 1;
      if (y > 1) y = 1;
      crsr = 5'(x + COLS * y);
      esc_mode = 0;
      push_goto();
    end else if (letter(k, "p") && esc_count == 2) begin
      if (letter(esc_bytes[1], "l")) begin
        if (crsr > 0) crsr--;
      end else if (letter(esc_bytes[1], "r")) begin
        if (crsr < CELLS - 1) crsr++;
      end else if (letter(esc_bytes[1], "u")) begin
        if (crsr >= COLS) crsr = crsr - 5'(COLS);
      end else if (letter(esc_bytes[1], "d")) begin
        if (crsr < COLS) crsr = crsr + 5'(COLS);
      end
      esc_mode = 0;
      push_goto();
    end
  endtask

  task automatic predict_terminal(input logic [7:0] c);
    lcd_write_t w;
    step_writes.delete();
    if (c == CH_ESC) begin
      esc_mode = 1;
      esc_count = 0;
    end else if (esc_mode) begin
      if (esc_count < 3) esc_bytes[esc_count] = c;
      esc_count++;
      if (esc_count >= 4) esc_mode = 0;
      run_escape();
    end else if (c == CH_CR) begin
      if (crsr >= COLS) scroll_screen();
      else begin
        for (int i = crsr; i < COLS; i++) screen[i] = CH_SPACE;
        crsr = 5'(COLS);
      end
      push_refresh();
    end else if (c == CH_BS) begin
      if (crsr > 0) begin
        crsr--;
        screen[crsr] = CH_SPACE;
        push_refresh();
      end
    end else begin
      screen[crsr] = c;
      if (crsr == CELLS - 1) scroll_screen();
      else crsr++;
      push_refresh();
    end
    if (step_writes.size() == 0) begin
      w.has_write = 0;
      w.register_select = 0;
      w.lcd_byte = 0;
      w.backlight_on = 0;
      w.last = 0;
      step_writes.push_back(w);
    end
    foreach (step_writes[i]) begin
      w = step_writes[i];
      w.backlight_on = lit;
      w.last = (i == step_writes.size() - 1);
      expected_writes.push_back(w);
    end
  endtask

  function automatic logic [7:0] random_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 8'($urandom_range(8'h20, 8'h7E));
    if (r < 65) return CH_CR;
    if (r < 72) return CH_BS;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] random_command();
    logic [7:0] letters[8] = '{"c", "l", "d", "e", "n", "f", "g", "p"};
    logic [7:0] b;
    b = letters[$urandom_range(0, 7)];
    if ($urandom_range(0, 1)) b = b & 8'hDF;
    return b;
  endfunction

  task automatic queue_random_sequence();
    logic [7:0] k;
    logic [7:0] dirs[5] = '{"l", "r", "u", "d", "x"};
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      pending_bytes.push_back(random_byte());
    end else if (r < 92) begin
      k = random_command();
      pending_bytes.push_back(CH_ESC);
      pending_bytes.push_back(k);
      if (letter(k, "g")) begin
        pending_bytes.push_back(8'($urandom_range(0, 5) ? $urandom_range(8'h30, 8'h3F) :
                                  $urandom_range(0, 255)));
        pending_bytes.push_back(8'($urandom_range(0, 5) ? $urandom_range(8'h30, 8'h31) :
                                  $urandom_range(0, 255)));
      end else if (letter(k, "p")) begin
        pending_bytes.push_back(dirs[$urandom_range(0, 4)] &
                                ($urandom_range(0, 1) ? 8'hFF : 8'hDF));
      end
    end else begin
      pending_bytes.push_back(CH_ESC);
      for (int i = $urandom_range(0, 4); i > 0; i--)
        pending_bytes.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    rst_n = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding.",
               cycles, expected_writes.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 0;
      in_rx_byte <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_terminal(in_rx_byte);
        bytes_sent <= bytes_sent + 1;
      end
      if (!in_valid || !in_stall) begin
        if (pending_bytes.size() > 0 && !hold_sender &&
            (calm || $urandom_range(0, 99) >= 27)) begin
          in_valid <= 1;
          in_rx_byte <= pending_bytes.pop_front();
        end else begin
          in_valid <= 0;
        end
      end
    end
  end

  always @(posedge clk) begin
    lcd_write_t w;
    if (!rst_n) begin
      out_stall <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen <= results_seen + 1;
        if (expected_writes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected result item: lcd_byte %h", out_lcd_byte);
        end else begin
          w = expected_writes.pop_front();
          if (out_has_write !== w.has_write || out_register_select !== w.register_select ||
              out_lcd_byte !== w.lcd_byte || out_backlight_on !== w.backlight_on ||
              out_last !== w.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Mismatch: expected w%b rs%b %h bl%b l%b, got w%b rs%b %h bl%b l%b",
                       w.has_write, w.register_select, w.lcd_byte, w.backlight_on, w.last,
                       out_has_write, out_register_select, out_lcd_byte, out_backlight_on,
                       out_last);
          end
        end
      end
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        out_stall <= 1;
      end else begin
        out_stall <= !calm && ($urandom_range(0, 99) < 27);
      end
    end
  end

  task automatic wait_drained();
    while (pending_bytes.size() > 0 || in_valid || expected_writes.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    logic [7:0] directed[$];
    for (int i = 0; i < CELLS; i++) begin
      screen[i] = CH_SPACE;
    end
    crsr = 0;
    esc_mode = 0;
    esc_count = 0;
    esc_bytes = '{default: 8'h00};
    lit = 1;
    mismatches = 0;
    results_seen = 0;
    bytes_sent = 0;
    cycles = 0;
    calm = 0;
    hold_sender = 0;
    hold_off = 0;
    wait (rst_n === 1'b1);
    @(posedge clk);

    directed = {8'h08, 8'h41, 8'hFF, 8'h00, 8'h0D, 8'h0D, 8'h1B, 8'h66, 8'h1B, 8'h4E,
                8'h1B, 8'h67, 8'h3F, 8'h39, 8'h1B, 8'h70, 8'h52, 8'h1B, 8'h1B, 8'h64,
                8'h1B, 8'h7A, 8'h01, 8'h02, 8'h03};
    foreach (directed[i]) pending_bytes.push_back(directed[i]);
    for (int i = 0; i < 36; i++) pending_bytes.push_back(8'($urandom_range(8'h21, 8'h7E)));
    wait_drained();

    hold_off = 400;
    repeat (40) queue_random_sequence();
    wait_drained();

    hold_sender = 1;
    repeat (30) @(posedge clk);
    hold_sender = 0;
    calm = 1;
    repeat (25) queue_random_sequence();
    wait_drained();
    calm = 0;
    repeat (55) queue_random_sequence();
    wait_drained();
    repeat (20) @(posedge clk);

    $display("Sent %0d bytes: text, scrolling, CR and BS, and every escape command.",
             bytes_sent);
    $display("Checked %0d result items, %0d mismatches.", results_seen, mismatches);
    if (mismatches == 0 && expected_writes.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
